// File: hw/rtl/fbc_pkg.sv
// Shared types and codes for the free-block cache with chain refill.
package fbc_pkg;

  localparam int unsigned WORD_W   = 32;
  localparam int unsigned COUNT_W  = 7;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned OP_W     = 2;

  // Operation codes of an input word
  typedef enum logic [OP_W-1:0] {
    OP_ALLOC   = 2'd0,
    OP_FREE    = 2'd1,
    OP_CHAIN   = 2'd2,
    OP_RESTORE = 2'd3
  } op_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_EMPTY   = 3'd1,
    ST_FILLED  = 3'd2,
    ST_BROKEN  = 3'd3,
    ST_IGNORED = 3'd4,
    ST_TAKEN   = 3'd5,
    ST_LEAKED  = 3'd6
  } status_t;

  // Shift control broadcast to every stack cell
  typedef struct packed {
    logic push;  // shift toward the bottom, new word enters at the top
    logic pop;   // shift toward the top
  } cell_ctl_t;

endpackage

// File: hw/rtl/fbc_cell.sv
// One entry of the free stack: a register that shifts up or down with its neighbors.
module fbc_cell (
  input  logic                          clk,
  input  fbc_pkg::cell_ctl_t            ctl,
  input  logic [fbc_pkg::WORD_W-1:0]    from_above,
  input  logic [fbc_pkg::WORD_W-1:0]    from_below,
  output logic [fbc_pkg::WORD_W-1:0]    data_q
);
  import fbc_pkg::*;

  logic [WORD_W-1:0] data_r;
  logic [WORD_W-1:0] data_nxt;

  // Take the word from the upper neighbor on push, the lower one on pop, else hold
  always_comb begin
    data_nxt = data_r;
    if (ctl.push) begin
      data_nxt = from_above;
    end else if (ctl.pop) begin
      data_nxt = from_below;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_q = data_r;

endmodule

// File: hw/rtl/free_block_cache_chain_refill.sv
// Top level: free-block stack allocator built as a shifting chain of cells.
//
//   Channel  Direction  Handshake         Word
//   in_      input      in_valid/in_stall  op, block_value, chain_last
//   out_     output     out_valid/out_stall status, given_block, fetch_chain,
//                                          cached_count, total_free_out
//   cfg_     input      cfg_we             volume_blocks
//
// The top of the stack is always cell 0, so a push or pop is one shift of the
// whole cell chain and the result is registered.
// One word is accepted per cycle while in_stall is low; the result appears the cycle after acceptance.
// in_stall rises only while a finished result is held by out_stall.
// Synchronous active-low reset clears counters, the load state and out_valid;
// stack cells are not reset and are never read before being written.
module free_block_cache_chain_refill #(
  parameter int unsigned STACK_DEPTH = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [fbc_pkg::WORD_W-1:0]      cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [fbc_pkg::OP_W-1:0]        in_op,
  input  logic [fbc_pkg::WORD_W-1:0]      in_block_value,
  input  logic                            in_chain_last,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [fbc_pkg::STATUS_W-1:0]    out_status,
  output logic [fbc_pkg::WORD_W-1:0]      out_given_block,
  output logic                            out_fetch_chain,
  output logic [fbc_pkg::COUNT_W-1:0]     out_cached_count,
  output logic [fbc_pkg::WORD_W-1:0]      out_total_free_out
);
  import fbc_pkg::*;

  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned RW = $clog2(STACK_DEPTH + 3);
  localparam logic [CW-1:0] DEPTH_C    = CW'(STACK_DEPTH);
  localparam logic [RW-1:0] RECV_DEPTH = RW'(STACK_DEPTH);
  localparam logic [RW-1:0] RECV_MAX   = RW'(STACK_DEPTH + 2);
  localparam logic [WORD_W-1:0] DEPTH_W = WORD_W'(STACK_DEPTH);

  // State registers
  logic [WORD_W-1:0] volume_blocks_r;
  logic [CW-1:0]     count_r, count_nxt;
  logic [WORD_W-1:0] total_r, total_nxt;
  logic [WORD_W-1:0] exp_r, exp_nxt;
  logic [RW-1:0]     recv_r, recv_nxt;
  logic              bad_r, bad_nxt;

  // Output registers
  logic              out_valid_r;
  status_t           status_r, status_nxt;
  logic [WORD_W-1:0] given_r, given_nxt;
  logic              fetch_r, fetch_nxt;
  logic [COUNT_W-1:0] cached_r;
  logic [WORD_W-1:0] total_out_r;

  logic       accept;
  cell_ctl_t  ctl;
  op_t        op;
  logic [WORD_W-1:0] cell_q [STACK_DEPTH];

  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;
  assign op       = op_t'(in_op);

  // Build the cell chain; cell 0 is the top of the stack
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [WORD_W-1:0] above;
    logic [WORD_W-1:0] below;
    if (i == 0) begin : g_top
      assign above = in_block_value;
    end else begin : g_mid
      assign above = cell_q[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_bot
      assign below = '0;
    end else begin : g_up
      assign below = cell_q[i+1];
    end
    fbc_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .from_above (above),
      .from_below (below),
      .data_q     (cell_q[i])
    );
  end

  // Decode one word and compute the next state and its result
  always_comb begin
    logic [RW-1:0] recv_inc;
    count_nxt  = count_r;
    total_nxt  = total_r;
    exp_nxt    = exp_r;
    recv_nxt   = recv_r;
    bad_nxt    = bad_r;
    status_nxt = ST_OK;
    given_nxt  = '0;
    fetch_nxt  = 1'b0;
    ctl        = '0;
    recv_inc   = recv_r;
    case (op)
      OP_ALLOC: begin
        if (count_r == '0) begin
          status_nxt = ST_EMPTY;
        end else begin
          ctl.pop   = 1'b1;
          count_nxt = count_r - CW'(1);
          given_nxt = cell_q[0];
          if (total_r != '0) begin
            total_nxt = total_r - WORD_W'(1);
          end
          if (count_r == CW'(1) && cell_q[0] != '0) begin
            fetch_nxt = 1'b1;
            exp_nxt   = '0;
            recv_nxt  = '0;
            bad_nxt   = 1'b0;
          end
        end
      end
      OP_FREE: begin
        if (in_block_value == '0) begin
          status_nxt = ST_IGNORED;
        end else if (count_r == DEPTH_C) begin
          status_nxt = ST_LEAKED;
        end else begin
          ctl.push  = 1'b1;
          count_nxt = count_r + CW'(1);
          if (total_r != '1) begin
            total_nxt = total_r + WORD_W'(1);
          end
          exp_nxt  = '0;
          recv_nxt = '0;
          bad_nxt  = 1'b0;
        end
      end
      OP_CHAIN: begin
        if (count_r != '0) begin
          status_nxt = ST_IGNORED;
        end else begin
          // Count word first, then entries pushed in order
          if (recv_r == '0) begin
            exp_nxt = in_block_value;
            if (in_block_value == '0 || in_block_value > DEPTH_W) begin
              bad_nxt = 1'b1;
            end
          end else if (recv_r <= RECV_DEPTH) begin
            ctl.push = 1'b1;
            if (in_block_value >= volume_blocks_r) begin
              bad_nxt = 1'b1;
            end
          end else begin
            bad_nxt = 1'b1;
          end
          if (recv_r < RECV_MAX) begin
            recv_inc = recv_r + RW'(1);
          end
          recv_nxt = recv_inc;
          if (in_chain_last) begin
            if (!bad_nxt &&
                ({1'b0, exp_nxt} + (WORD_W+1)'(1)) == (WORD_W+1)'(recv_inc)) begin
              count_nxt  = CW'(exp_nxt);
              status_nxt = ST_FILLED;
            end else begin
              status_nxt = ST_BROKEN;
            end
            exp_nxt  = '0;
            recv_nxt = '0;
            bad_nxt  = 1'b0;
          end else begin
            status_nxt = ST_TAKEN;
          end
        end
      end
      OP_RESTORE: begin
        total_nxt = in_block_value;
      end
      default: begin
        status_nxt = ST_OK;
      end
    endcase
    if (!accept) begin
      ctl = '0;
    end
  end

  // Hold the volume size register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      volume_blocks_r <= '0;
    end else if (cfg_we) begin
      volume_blocks_r <= cfg_wdata;
    end
  end

  // Advance counters and load state on an accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      total_r <= '0;
      exp_r   <= '0;
      recv_r  <= '0;
      bad_r   <= 1'b0;
    end else if (accept) begin
      count_r <= count_nxt;
      total_r <= total_nxt;
      exp_r   <= exp_nxt;
      recv_r  <= recv_nxt;
      bad_r   <= bad_nxt;
    end
  end

  // Output valid: set on accept, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Capture the result word
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r    <= status_nxt;
      given_r     <= given_nxt;
      fetch_r     <= fetch_nxt;
      cached_r    <= COUNT_W'(count_nxt);
      total_out_r <= total_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = status_r;
  assign out_given_block    = given_r;
  assign out_fetch_chain    = fetch_r;
  assign out_cached_count   = cached_r;
  assign out_total_free_out = total_out_r;

  // Stack never holds more than its depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_C)
    else $error("stack count above depth");

  // Word counter stops at its limit
  a_recv_bound: assert property (@(posedge clk) disable iff (!rst_n)
    recv_r <= RECV_MAX)
    else $error("chain word counter past limit");

  // A chain fetch request leaves an empty stack and a clean load state
  a_fetch_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && fetch_nxt |=> count_r == '0 && recv_r == '0 && !bad_r)
    else $error("fetch request left stale state");

  // A successful free grows the stack by one
  a_free_grows: assert property (@(posedge clk) disable iff (!rst_n)
    accept && op == OP_FREE && status_nxt == ST_OK |=>
      count_r == $past(count_r) + CW'(1))
    else $error("free did not push");

  // Chain words are only taken into an empty stack
  a_chain_empty: assert property (@(posedge clk) disable iff (!rst_n)
    accept && op == OP_CHAIN && count_r != '0 |-> status_nxt == ST_IGNORED && !ctl.push)
    else $error("chain word taken into a loaded stack");

endmodule

// File: tb/fbc_ledger_pkg.sv
// Scoreboard class that tracks the free-block stack and checks each result word.
package fbc_ledger_pkg;

  import fbc_pkg::*;

  localparam int unsigned STACK_WORDS = 64;

  // One result word as the block should present it
  typedef struct packed {
    status_t                status;
    logic [WORD_W-1:0]      given_block;
    logic                   fetch_chain;
    logic [COUNT_W-1:0]     cached_count;
    logic [WORD_W-1:0]      total_free_out;
  } fbc_result_t;

  class fbc_ledger;

    // Mirror of the allocator state
    logic [WORD_W-1:0] stack [STACK_WORDS];
    int unsigned       depth = 0;
    logic [WORD_W-1:0] total = '0;
    logic [WORD_W-1:0] volume = '0;
    logic [WORD_W-1:0] load_count = '0;
    int unsigned       load_words = 0;
    bit                load_bad = 1'b0;

    fbc_result_t       results_due[$];
    int unsigned       faults = 0;

    function void drop_load();
      load_count = '0;
      load_words = 0;
      load_bad   = 1'b0;
    endfunction

    function int unsigned pending();
      return results_due.size();
    endfunction

    // Apply one accepted input word and queue the result it must produce
    function status_t note_word(op_t op, logic [WORD_W-1:0] val, logic last);
      fbc_result_t r;
      r.status      = ST_OK;
      r.given_block = '0;
      r.fetch_chain = 1'b0;
      case (op)
        OP_ALLOC: begin
          if (depth == 0) begin
            r.status = ST_EMPTY;
          end else begin
            depth--;
            r.given_block = stack[depth];
            stack[depth] = '0;
            if (total != '0) total--;
            // popping the last nonzero block asks for a chain refill
            if (depth == 0 && r.given_block != '0) begin
              r.fetch_chain = 1'b1;
              drop_load();
            end
          end
        end
        OP_FREE: begin
          if (val == '0) begin
            r.status = ST_IGNORED;
          end else if (depth >= STACK_WORDS) begin
            r.status = ST_LEAKED;
          end else begin
            stack[depth] = val;
            depth++;
            if (total != '1) total++;
            drop_load();
          end
        end
        OP_CHAIN: begin
          if (depth != 0) begin
            r.status = ST_IGNORED;
          end else begin
            // first word is the entry count, the rest are entries
            if (load_words == 0) begin
              load_count = val;
              if (val == '0 || val > STACK_WORDS) load_bad = 1'b1;
            end else if (load_words - 1 < STACK_WORDS) begin
              stack[load_words - 1] = val;
              if (val >= volume) load_bad = 1'b1;
            end else begin
              load_bad = 1'b1;
            end
            if (load_words < STACK_WORDS + 2) load_words++;
            if (last) begin
              if (!load_bad && 64'(load_count) + 64'd1 == 64'(load_words)) begin
                depth = load_count;
                r.status = ST_FILLED;
              end else begin
                r.status = ST_BROKEN;
              end
              drop_load();
            end else begin
              r.status = ST_TAKEN;
            end
          end
        end
        default: begin
          total = val;
        end
      endcase
      r.cached_count   = COUNT_W'(depth);
      r.total_free_out = total;
      results_due.push_back(r);
      return r.status;
    endfunction

    // Compare one accepted result word with the oldest expectation
    function void check_result(status_t status, logic [WORD_W-1:0] given, logic fetch,
                               logic [COUNT_W-1:0] count, logic [WORD_W-1:0] total_out);
      fbc_result_t want;
      if (results_due.size() == 0) begin
        faults++;
        if (faults <= 10)
          $display("unexpected result word: status %0d given %h count %0d",
                   status, given, count);
        return;
      end
      want = results_due.pop_front();
      if (status !== want.status || given !== want.given_block ||
          fetch !== want.fetch_chain || count !== want.cached_count ||
          total_out !== want.total_free_out) begin
        faults++;
        if (faults <= 10)
          $display({"result differs: status %0d/%0d given %h/%h fetch %b/%b ",
                    "count %0d/%0d total %h/%h (expected/actual)"},
                   want.status, status, want.given_block, given,
                   want.fetch_chain, fetch, want.cached_count, count,
                   want.total_free_out, total_out);
      end
    endfunction

  endclass

endpackage

// File: tb/free_block_cache_chain_refill_tb.sv
// Testbench top: drives the free-block cache and checks every result word.
module free_block_cache_chain_refill_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import fbc_pkg::*;
  import fbc_ledger_pkg::*;

  localparam int unsigned IDLE_LIMIT  = 5000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned PHASE_WORDS = 160;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic [WORD_W-1:0]   cfg_wdata = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [OP_W-1:0]     in_op = OP_ALLOC;
  logic [WORD_W-1:0]   in_block_value = '0;
  logic                in_chain_last = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic [WORD_W-1:0]   out_given_block;
  logic                out_fetch_chain;
  logic [COUNT_W-1:0]  out_cached_count;
  logic [WORD_W-1:0]   out_total_free_out;

  fbc_ledger   ledger = new();
  int unsigned send_idle_pct = 7;
  int unsigned recv_idle_pct = 53;
  int unsigned hold_asked = 0;
  int unsigned hold_taken = 0;
  int unsigned hold_left = 0;
  int unsigned words_counted = 0;
  int unsigned quiet_cycles = 0;

  free_block_cache_chain_refill #(
    .STACK_DEPTH(STACK_WORDS)
  ) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_op              (in_op),
    .in_block_value     (in_block_value),
    .in_chain_last      (in_chain_last),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_given_block    (out_given_block),
    .out_fetch_chain    (out_fetch_chain),
    .out_cached_count   (out_cached_count),
    .out_total_free_out (out_total_free_out)
  );

  always #4 clk = ~clk;

  // Receiver: random stalls, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (hold_left == 0 && hold_taken != hold_asked) begin
      hold_taken = hold_asked;
      hold_left  = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Sample both channels mid-cycle; check results and watch for a hang
  always @(negedge clk) begin
    if (rst_n && out_valid && !out_stall)
      ledger.check_result(status_t'(out_status), out_given_block, out_fetch_chain,
                          out_cached_count, out_total_free_out);
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("free_block_cache_chain_refill: mismatch");
        $finish;
      end
    end
  end

  // Offer one word, hold it until accepted, then note it in the ledger
  task automatic send_word(op_t op, logic [WORD_W-1:0] val, logic last);
    bit      taken;
    status_t st;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_op          <= op;
    in_block_value <= val;
    in_chain_last  <= last;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end
    st = ledger.note_word(op, val, last);
    if (st != ST_IGNORED) words_counted++;
  endtask

  // Drop valid and wait until every result word is back
  task automatic settle();
    in_valid <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_volume(logic [WORD_W-1:0] vol);
    cfg_we    <= 1'b1;
    cfg_wdata <= vol;
    @(posedge clk);
    cfg_we <= 1'b0;
    ledger.volume = vol;
  endtask

  // Chain entry below the volume size, zero now and then, or one out of range
  function automatic logic [WORD_W-1:0] pick_entry(bit stray);
    logic [WORD_W-1:0] vol;
    vol = ledger.volume;
    if (vol == '0) return $urandom;
    if (stray) return $urandom_range(32'hFFFF_FFFF, vol);
    if ($urandom_range(9) == 0) return '0;
    return $urandom_range(vol - 1, 0);
  endfunction

  // Empty the stack, then load a chain block, well formed or damaged
  task automatic load_chain();
    int unsigned       n, sent, stray_at, kind;
    logic [WORD_W-1:0] cnt;
    while (ledger.depth != 0)
      send_word(OP_ALLOC, $urandom, 1'($urandom_range(1)));
    kind = $urandom_range(11);
    n = ($urandom_range(7) == 0) ? $urandom_range(STACK_WORDS, STACK_WORDS - 4)
                                 : $urandom_range(8, 1);
    cnt = n;
    sent = n;
    stray_at = $urandom_range(n, 1);
    case (kind)
      0: cnt = ($urandom_range(1) == 0) ? 32'd0 : $urandom_range(32'hFFFF_FFFF, 65);
      2: sent = n - 1;
      3: sent = n + 1;
      4: begin
        cnt  = STACK_WORDS;
        sent = STACK_WORDS + $urandom_range(4, 1);
      end
      default: ;
    endcase
    send_word(OP_CHAIN, cnt, sent == 0);
    for (int i = 1; i <= sent; i++) begin
      // abandon the load halfway with a successful free
      if (kind == 5 && i == (sent + 1) / 2)
        send_word(OP_FREE, $urandom | 32'd1, 1'b0);
      send_word(OP_CHAIN, pick_entry(kind == 1 && i == stray_at), i == sent);
    end
  endtask

  task automatic free_burst();
    int unsigned k;
    k = ($urandom_range(5) == 0) ? STACK_WORDS - ledger.depth + $urandom_range(4, 1)
                                 : $urandom_range(6, 1);
    repeat (k)
      send_word(OP_FREE, ($urandom_range(15) == 0) ? 32'd0 : $urandom,
                1'($urandom_range(1)));
  endtask

  task automatic run_phase(int unsigned s_pct, int unsigned r_pct,
                           logic [WORD_W-1:0] vol, bit squeeze);
    int unsigned       roll;
    logic [WORD_W-1:0] restored;
    settle();
    write_volume(vol);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    if (squeeze) hold_asked++;
    words_counted = 0;
    while (words_counted < PHASE_WORDS) begin
      roll = $urandom_range(99);
      if (roll < 35) begin
        load_chain();
      end else if (roll < 55) begin
        free_burst();
      end else if (roll < 75) begin
        repeat ($urandom_range(ledger.depth + 1, 1))
          send_word(OP_ALLOC, $urandom, 1'($urandom_range(1)));
      end else if (roll < 83) begin
        case ($urandom_range(4))
          0: restored = '0;
          1: restored = '1;
          2: restored = 32'hFFFF_FFFE;
          default: restored = $urandom;
        endcase
        send_word(OP_RESTORE, restored, 1'($urandom_range(1)));
      end else begin
        repeat ($urandom_range(4, 1))
          send_word(op_t'($urandom_range(3)), $urandom, 1'($urandom_range(1)));
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_volume(32'd1000);

    // Directed: empty stack, zero free, saturating total, chain loads good and bad
    send_word(OP_ALLOC, 32'd0, 1'b0);
    send_word(OP_FREE, 32'd0, 1'b0);
    send_word(OP_FREE, 32'd5, 1'b0);
    send_word(OP_CHAIN, 32'd2, 1'b1);
    send_word(OP_RESTORE, 32'd0, 1'b0);
    send_word(OP_ALLOC, 32'd0, 1'b0);
    send_word(OP_ALLOC, 32'd0, 1'b0);
    send_word(OP_RESTORE, 32'hFFFF_FFFF, 1'b0);
    send_word(OP_FREE, 32'hFFFF_FFFF, 1'b1);
    send_word(OP_ALLOC, 32'hFFFF_FFFF, 1'b1);
    send_word(OP_CHAIN, 32'd3, 1'b0);
    send_word(OP_CHAIN, 32'd999, 1'b0);
    send_word(OP_CHAIN, 32'd0, 1'b0);
    send_word(OP_CHAIN, 32'd1, 1'b1);
    send_word(OP_ALLOC, 32'd0, 1'b0);
    send_word(OP_ALLOC, 32'd0, 1'b0);
    send_word(OP_ALLOC, 32'd0, 1'b0);
    // a zero block popped last asks for no refill
    send_word(OP_CHAIN, 32'd1, 1'b0);
    send_word(OP_CHAIN, 32'd0, 1'b1);
    send_word(OP_ALLOC, 32'd0, 1'b0);
    send_word(OP_CHAIN, 32'd0, 1'b1);
    send_word(OP_CHAIN, 32'd65, 1'b0);
    send_word(OP_CHAIN, 32'd7, 1'b1);
    send_word(OP_CHAIN, 32'd1, 1'b0);
    send_word(OP_CHAIN, 32'd1000, 1'b1);
    send_word(OP_CHAIN, 32'd2, 1'b0);
    send_word(OP_CHAIN, 32'd4, 1'b0);
    send_word(OP_FREE, 32'd8, 1'b0);
    send_word(OP_ALLOC, 32'd0, 1'b0);
    send_word(OP_CHAIN, 32'd1, 1'b1);

    // Volume extremes: nothing fits below zero, everything below the maximum
    settle();
    write_volume(32'd0);
    send_word(OP_CHAIN, 32'd1, 1'b0);
    send_word(OP_CHAIN, 32'd0, 1'b1);
    settle();
    write_volume(32'hFFFF_FFFF);
    send_word(OP_CHAIN, 32'd1, 1'b0);
    send_word(OP_CHAIN, 32'hFFFF_FFFE, 1'b1);

    // Random phases: sender idles little, then receiver idles little, then neither
    run_phase(7, 53, 32'd1000, 1'b0);
    run_phase(53, 7, 32'hFFFF_FFFF, 1'b0);
    run_phase(0, 0, $urandom | 32'h100, 1'b1);

    settle();
    repeat (20) @(posedge clk);
    if (ledger.faults == 0 && ledger.pending() == 0)
      $display("free_block_cache_chain_refill: match");
    else
      $display("free_block_cache_chain_refill: mismatch");
    $finish;
  end

endmodule
